// ----- hdl/json_string_unescape_utf8_macros.svh -----
// Assertion macros for the JSON string unescaper.
// Included by the top level; no other dependencies.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define JSU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/jsu_pkg.sv -----
// Shared types, constants and character helpers for the JSON string unescaper.
// No dependencies.
package jsu_pkg;

  localparam int MAX_RES = 3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [15:0] UTF8_1B_MAX = 16'h007F;
  localparam logic [15:0] UTF8_2B_MAX = 16'h07FF;
  localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
  localparam logic [7:0]  UTF8_CONT   = 8'h80;

  typedef enum logic [2:0] {
    MODE_DONE  = 3'd0,
    MODE_PLAIN = 3'd1,
    MODE_ESC   = 3'd2,
    MODE_HEX0  = 3'd3,
    MODE_HEX1  = 3'd4,
    MODE_HEX2  = 3'd5,
    MODE_HEX3  = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ST_DATA   = 2'd0,
    ST_CLOSE  = 2'd1,
    ST_BADHEX = 2'd2,
    ST_TRUNC  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    status_t    status;
    logic       last;
  } result_t;

  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic [1:0]            cnt;
  } batch_t;

  typedef struct packed {
    logic       can_load;
    logic [1:0] cnt;
  } buf_stat_t;

  // Returns {valid, nibble} for an ASCII hex digit in either case.
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    v = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return v;
  endfunction

  // Map the character after a backslash to the byte it stands for.
  function automatic logic [7:0] escape_byte(logic [7:0] c);
    logic [7:0] v;
    case (c)
      8'h62:   v = 8'h08;
      8'h66:   v = 8'h0C;
      8'h6E:   v = 8'h0A;
      8'h72:   v = 8'h0D;
      8'h74:   v = 8'h09;
      default: v = c;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/json_string_unescape_utf8.sv -----
// JSON string body unescaper with UTF-8 output. Feed the bytes after the opening
// quote, one per beat, with in_tuser set on the first and in_tlast on the last byte
// available. One input beat is taken per cycle unless the output stalls; a \u
// escape that expands to two or three UTF-8 bytes holds in_tready low while the
// three-entry result buffer drains one beat per cycle with out_tready high. Status
// beats (close, bad hex, truncated) carry a zero byte and always end their run;
// after one, bytes are dropped until the next beat with in_tuser set. Data already
// sent for a failed string is to be discarded. Depends on jsu_pkg, jsu_in_stage,
// jsu_decode, jsu_res_buf and the macros header.
`include "json_string_unescape_utf8_macros.svh"

module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] starts_string
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] status
  output logic       out_tlast
);
  import jsu_pkg::*;

  item_t     in_item, s1_item;
  logic      s1_vld, s1_adv;
  batch_t    batch;
  buf_stat_t bstat;
  result_t   out_res;

  assign in_item = '{data: in_tdata, start: in_tuser, last: in_tlast};
  assign s1_adv  = s1_vld && bstat.can_load;

  jsu_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .adv       (s1_adv),
    .vld       (s1_vld),
    .item      (s1_item)
  );

  jsu_decode u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (s1_item),
    .adv   (s1_adv),
    .batch (batch)
  );

  jsu_res_buf u_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_adv),
    .batch      (batch),
    .stat       (bstat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = out_res.data;
  assign out_tuser = out_res.status;
  assign out_tlast = out_res.last;

  `JSU_ASSERT_IMPL(a_status_ends_run, clk, rst_n, out_tvalid && out_tuser != ST_DATA, out_tlast, "status beat without tlast")
  `JSU_ASSERT_IMPL(a_status_zero_byte, clk, rst_n, out_tvalid && out_tuser != ST_DATA, out_tdata == 8'd0, "status beat with nonzero byte")
  `JSU_ASSERT_IMPL(a_no_overwrite, clk, rst_n, s1_adv, bstat.cnt == 2'd0 || (bstat.cnt == 2'd1 && out_tready), "result buffer overwritten")
  `JSU_ASSERT_NEXT(a_stall_holds, clk, rst_n, s1_vld && !s1_adv, s1_vld, "pending item lost")

endmodule

// ----- hdl/jsu_in_stage.sv -----
// Input register stage of the JSON string unescaper.
// Depends on jsu_pkg.
module jsu_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  jsu_pkg::item_t in_item,
  input  logic           adv,
  output logic           vld,
  output jsu_pkg::item_t item
);
  import jsu_pkg::*;

  logic  vld_r;
  item_t item_r;

  assign in_tready = !vld_r || adv;
  assign vld       = vld_r;
  assign item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- hdl/jsu_decode.sv -----
// Escape decoder: mode and hex accumulator, plus per-byte result generation.
// Depends on jsu_pkg.
module jsu_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  jsu_pkg::item_t  item,
  input  logic            adv,
  output jsu_pkg::batch_t batch
);
  import jsu_pkg::*;

  mode_t       mode_r, mode_nxt, mode_eff;
  logic [11:0] acc_r, acc_nxt, acc_eff;
  logic [4:0]  hv;
  logic [15:0] cp;
  result_t [MAX_RES-1:0] res;
  logic [1:0]  cnt;

  always_comb begin
    mode_eff = item.start ? MODE_PLAIN : mode_r;
    acc_eff  = item.start ? 12'd0 : acc_r;
    mode_nxt = mode_eff;
    acc_nxt  = acc_eff;
    hv       = hex_value(item.data);
    cp       = {acc_eff, hv[3:0]};
    res      = '0;
    cnt      = 2'd0;

    case (mode_eff)
      MODE_DONE: begin
        mode_nxt = MODE_DONE;
      end
      MODE_PLAIN: begin
        if (item.data == CH_QUOTE) begin
          res[0]   = '{data: 8'd0, status: ST_CLOSE, last: 1'b0};
          cnt      = 2'd1;
          mode_nxt = MODE_DONE;
        end else if (item.data == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          res[0] = '{data: item.data, status: ST_DATA, last: 1'b0};
          cnt    = 2'd1;
        end
      end
      MODE_ESC: begin
        if (item.data == CH_U) begin
          acc_nxt  = 12'd0;
          mode_nxt = MODE_HEX0;
        end else begin
          res[0]   = '{data: escape_byte(item.data), status: ST_DATA, last: 1'b0};
          cnt      = 2'd1;
          mode_nxt = MODE_PLAIN;
        end
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2: begin
        if (!hv[4]) begin
          res[0]   = '{data: 8'd0, status: ST_BADHEX, last: 1'b0};
          cnt      = 2'd1;
          mode_nxt = MODE_DONE;
        end else begin
          acc_nxt = {acc_eff[7:0], hv[3:0]};
          case (mode_eff)
            MODE_HEX0: mode_nxt = MODE_HEX1;
            MODE_HEX1: mode_nxt = MODE_HEX2;
            default:   mode_nxt = MODE_HEX3;
          endcase
        end
      end
      MODE_HEX3: begin
        if (!hv[4]) begin
          res[0]   = '{data: 8'd0, status: ST_BADHEX, last: 1'b0};
          cnt      = 2'd1;
          mode_nxt = MODE_DONE;
        end else begin
          if (cp <= UTF8_1B_MAX) begin
            res[0] = '{data: cp[7:0], status: ST_DATA, last: 1'b0};
            cnt    = 2'd1;
          end else if (cp <= UTF8_2B_MAX) begin
            res[0] = '{data: UTF8_LEAD2 | {3'd0, cp[10:6]}, status: ST_DATA, last: 1'b0};
            res[1] = '{data: UTF8_CONT | {2'd0, cp[5:0]}, status: ST_DATA, last: 1'b0};
            cnt    = 2'd2;
          end else begin
            res[0] = '{data: UTF8_LEAD3 | {4'd0, cp[15:12]}, status: ST_DATA, last: 1'b0};
            res[1] = '{data: UTF8_CONT | {2'd0, cp[11:6]}, status: ST_DATA, last: 1'b0};
            res[2] = '{data: UTF8_CONT | {2'd0, cp[5:0]}, status: ST_DATA, last: 1'b0};
            cnt    = 2'd3;
          end
          acc_nxt  = 12'd0;
          mode_nxt = MODE_PLAIN;
        end
      end
      default: begin
        mode_nxt = MODE_DONE;
      end
    endcase

    // Input ran out with the string still open: replace any data with one truncation beat.
    if (item.last && mode_nxt != MODE_DONE) begin
      res      = '0;
      res[0]   = '{data: 8'd0, status: ST_TRUNC, last: 1'b0};
      cnt      = 2'd1;
      mode_nxt = MODE_DONE;
      acc_nxt  = 12'd0;
    end

    for (int i = 0; i < MAX_RES; i++) begin
      res[i].last = (cnt == 2'(i + 1));
    end
  end

  assign batch = '{res: res, cnt: cnt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DONE;
      acc_r  <= 12'd0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// ----- hdl/jsu_res_buf.sv -----
// Three-entry result buffer; drains one beat per cycle from entry zero while out_tready is high.
// Depends on jsu_pkg.
module jsu_res_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  jsu_pkg::batch_t    batch,
  output jsu_pkg::buf_stat_t stat,
  output logic               out_tvalid,
  input  logic               out_tready,
  output jsu_pkg::result_t   out_res
);
  import jsu_pkg::*;

  result_t [MAX_RES-1:0] ent_r, ent_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  out_fire;

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_fire   = out_tvalid && out_tready;
  assign out_res    = ent_r[0];

  // Reload only when the buffer is empty or empties in this cycle.
  assign stat = '{can_load: (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready),
                  cnt:      cnt_r};

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (load) begin
      ent_nxt = batch.res;
      cnt_nxt = batch.cnt;
    end else if (out_fire) begin
      ent_nxt[0] = ent_r[1];
      ent_nxt[1] = ent_r[2];
      cnt_nxt    = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
